// ===== rtl/core/tmtw_pkg.sv =====
`timescale 1ns / 1ps

package tmtw_pkg;

  localparam int REQ_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;

  localparam logic [REQ_W-1:0] REQ_PRINT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'h0a;
  localparam logic [CELL_W-1:0]  BLANK_CELL       = 16'h0720;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_SCROLL_END
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] read_cell;
  } fin_t;

endpackage

// ===== rtl/core/tmtw_if.sv =====
`timescale 1ns / 1ps

interface tmtw_req_if
  import tmtw_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [CHAR_W-1:0]  char_code;
  logic [COLOR_W-1:0] entry_color;
  logic [COL_W-1:0]   col_x;
  logic [ROW_W-1:0]   row_y;

  modport source (output valid, req_type, char_code, entry_color, col_x, row_y, input ready);
  modport sink (input valid, req_type, char_code, entry_color, col_x, row_y, output ready);
endinterface

interface tmtw_rsp_if
  import tmtw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [CELL_W-1:0] read_cell;

  modport source (output valid, cursor_pos, read_cell, input ready);
  modport sink (input valid, cursor_pos, read_cell, output ready);
endinterface

// ===== rtl/core/tmtw_store.sv =====
`timescale 1ns / 1ps

module tmtw_store
  import tmtw_pkg::*;
#(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tmtw_result.sv =====
`timescale 1ns / 1ps

module tmtw_result
  import tmtw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  fin_t  fin,
  output logic  busy,
  tmtw_rsp_if.source rsp_ch
);

  logic              res_valid;
  logic              res_valid_next;
  logic [POS_W-1:0]  res_pos;
  logic [CELL_W-1:0] res_cell;
  logic              out_valid;
  logic              out_valid_next;
  logic [POS_W-1:0]  out_pos;
  logic [CELL_W-1:0] out_cell;
  logic              move;

  assign move = res_valid && (!out_valid || rsp_ch.ready);

  always_comb begin
    res_valid_next = res_valid;
    if (fin.valid) begin
      res_valid_next = 1'b1;
    end else if (move) begin
      res_valid_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (move) begin
      out_valid_next = 1'b1;
    end else if (rsp_ch.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) begin
      res_pos  <= fin.cursor_pos;
      res_cell <= fin.read_cell;
    end
    if (move) begin
      out_pos  <= res_pos;
      out_cell <= res_cell;
    end
  end

  assign busy              = res_valid;
  assign rsp_ch.valid      = out_valid;
  assign rsp_ch.cursor_pos = out_pos;
  assign rsp_ch.read_cell  = out_cell;

endmodule

// ===== rtl/core/tmtw_ctrl.sv =====
`timescale 1ns / 1ps

module tmtw_ctrl
  import tmtw_pkg::*;
#(
  parameter int COLS   = 80,
  parameter int ROWS   = 25,
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [COLOR_W-1:0]  cfg_wr_data,
  input  logic                busy,
  tmtw_req_if.sink            req_ch,
  output logic                we,
  output logic [ADDR_W-1:0]   waddr,
  output logic [CELL_W-1:0]   wdata,
  output logic [ADDR_W-1:0]   raddr,
  input  logic [CELL_W-1:0]   rdata,
  output fin_t                fin
);

  localparam logic [COL_W-1:0]  COLS_V     = COL_W'(COLS);
  localparam logic [ROW_W-1:0]  ROWS_V     = ROW_W'(ROWS);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'((ROWS - 1) * COLS - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN   = ADDR_W'(COLS);

  state_t             state;
  state_t             state_next;
  logic [ROW_W-1:0]   cursor_row;
  logic [ROW_W-1:0]   cursor_row_next;
  logic [COL_W-1:0]   cursor_col;
  logic [COL_W-1:0]   cursor_col_next;
  logic [COLOR_W-1:0] text_color;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  idx_next;
  logic               rd_hit;

  logic               accept;
  logic               xy_in;
  logic [ADDR_W-1:0]  xy_addr;
  logic [ADDR_W-1:0]  cur_addr;
  logic               is_print;
  logic               is_nl;
  logic               adv_row;
  logic               scroll;
  logic [POS_W-1:0]   pos_next;

  assign req_ch.ready = (state == ST_IDLE) && !busy;
  assign accept       = req_ch.valid && req_ch.ready;

  always_comb begin
    xy_in    = (req_ch.col_x < COLS_V) && (req_ch.row_y < ROWS_V);
    xy_addr  = ADDR_W'(int'(req_ch.row_y) * COLS + int'(req_ch.col_x));
    cur_addr = ADDR_W'(int'(cursor_row) * COLS + int'(cursor_col));
    is_print = (req_ch.req_type == REQ_PRINT);
    is_nl    = (req_ch.char_code == NEWLINE_CODE);
    adv_row  = is_nl || (cursor_col == COL_LAST);
    scroll   = is_print && adv_row && (cursor_row == ROW_LAST);

    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    if (accept && is_print) begin
      if (adv_row) begin
        cursor_col_next = '0;
        if (cursor_row != ROW_LAST) begin
          cursor_row_next = cursor_row + 1'b1;
        end
      end else begin
        cursor_col_next = cursor_col + 1'b1;
      end
    end
    pos_next = POS_W'(int'(cursor_row_next) * COLS + int'(cursor_col_next));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (idx == CLEAR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_ch.req_type == REQ_READ) begin
            state_next = ST_READ;
          end else if (scroll) begin
            state_next = ST_SCROLL;
          end
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        if (idx == COPY_LAST) begin
          state_next = ST_SCROLL_END;
        end
      end
      ST_SCROLL_END: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    we             = 1'b0;
    waddr          = cur_addr;
    wdata          = {text_color, req_ch.char_code};
    raddr          = xy_addr;
    idx_next       = idx;
    fin.valid      = 1'b0;
    fin.cursor_pos = pos_next;
    fin.read_cell  = '0;
    case (state)
      ST_CLEAR: begin
        we       = 1'b1;
        waddr    = idx;
        wdata    = BLANK_CELL;
        idx_next = (idx == CLEAR_LAST) ? '0 : idx + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          case (req_ch.req_type)
            REQ_PRINT: begin
              we        = !is_nl;
              fin.valid = !scroll;
            end
            REQ_WRITE: begin
              we        = xy_in;
              waddr     = xy_addr;
              wdata     = {req_ch.entry_color, req_ch.char_code};
              fin.valid = 1'b1;
            end
            REQ_READ: begin
              fin.valid = 1'b0;
            end
            default: begin
              fin.valid = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        fin.valid     = 1'b1;
        fin.read_cell = rd_hit ? rdata : '0;
      end
      ST_SCROLL: begin
        raddr    = idx + ROW_SPAN;
        we       = (idx != '0);
        waddr    = idx - 1'b1;
        wdata    = rdata;
        idx_next = (idx == COPY_LAST) ? idx : idx + 1'b1;
      end
      ST_SCROLL_END: begin
        we        = 1'b1;
        waddr     = idx;
        wdata     = rdata;
        idx_next  = '0;
        fin.valid = 1'b1;
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cursor_row <= '0;
      cursor_col <= '0;
      text_color <= TEXT_COLOR_RESET;
      idx        <= '0;
      rd_hit     <= 1'b0;
    end else begin
      state      <= state_next;
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
      idx        <= idx_next;
      if (cfg_wr_en) begin
        text_color <= cfg_wr_data;
      end
      if (accept) begin
        rd_hit <= xy_in;
      end
    end
  end

endmodule

// ===== rtl/core/text_mode_terminal_writer_top.sv =====
`timescale 1ns / 1ps

// Character-cell text terminal with a ROWS x COLS store of 16-bit cells (attribute in the
// high byte, character in the low byte) held in one memory with a registered read port,
// plus a row/column cursor. After reset the block fills all ROWS*COLS cells of the store
// with blank gray cells and takes no request meanwhile; text_color may be written at any
// time. After a print, a direct cell write or an unused request, no further request is
// taken until its result has moved from the holding register into the output register;
// a cell read first passes through a read state because of the registered memory read.
// A print that moves past the last row copies the screen up one row through the memory's
// read and write ports, one cell per cycle, and takes no request until the copy is done.
// Each transfer in gives exactly one transfer out, in order, carrying the cursor position
// after the request; results pass through a holding register and an output register, so
// intake continues while one result waits in the output register, but not while a second waits.
module text_mode_terminal_writer_top
  import tmtw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COLOR_W-1:0] cfg_wr_data,
  tmtw_req_if.sink           req_ch,
  tmtw_rsp_if.source         rsp_ch
);

  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;
  logic              busy;
  fin_t              fin;

  tmtw_ctrl #(
    .COLS   (COLS),
    .ROWS   (ROWS),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .busy        (busy),
    .req_ch      (req_ch),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr       (raddr),
    .rdata       (rdata),
    .fin         (fin)
  );

  tmtw_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tmtw_result u_result (
    .clk    (clk),
    .rst    (rst),
    .fin    (fin),
    .busy   (busy),
    .rsp_ch (rsp_ch)
  );

endmodule

// ===== tb/sv/text_mode_terminal_writer_top_tb.sv =====
`timescale 1ns / 1ps

module text_mode_terminal_writer_top_tb;
  import tmtw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = ROWS * COLS;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 12000;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 180;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] attr;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } term_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_word;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [COLOR_W-1:0] cfg_wr_data;

  tmtw_req_if req_ch ();
  tmtw_rsp_if rsp_ch ();

  text_mode_terminal_writer_top #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req_ch     (req_ch),
    .rsp_ch     (rsp_ch)
  );

  always #5 clk = ~clk;

  term_req_t pending_reqs[$];
  cell_result_t expected_results[$];
  term_req_t offered_req;

  logic [CELL_W-1:0] screen_model [CELLS];
  int cur_row;
  int cur_col;
  logic [COLOR_W-1:0] print_attr;

  int reqs_queued = 0;
  int results_seen = 0;
  int mismatches = 0;
  int src_idle_pct;
  int snk_idle_pct;
  int src_gap = 0;
  int snk_gap = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  logic hold_arm;

  int n_prints = 0;
  int n_writes = 0;
  int n_reads = 0;
  int n_unused = 0;
  int n_scrolls = 0;
  int n_wraps = 0;
  int n_colors = 0;

  task automatic advance_row();
    int i;
    cur_col = 0;
    if (cur_row == ROWS - 1) begin
      for (i = 0; i < (ROWS - 1) * COLS; i++) begin
        screen_model[i] = screen_model[i + COLS];
      end
      n_scrolls++;
    end else begin
      cur_row++;
    end
  endtask

  task automatic predict_request(input term_req_t r);
    logic [CELL_W-1:0] cell_val;
    logic in_range;
    cell_val = '0;
    in_range = (r.col < COLS) && (r.row < ROWS);
    case (r.kind)
      REQ_PRINT: begin
        n_prints++;
        if (r.glyph == NEWLINE_CODE) begin
          advance_row();
        end else begin
          screen_model[cur_row * COLS + cur_col] = {print_attr, r.glyph};
          cur_col++;
          if (cur_col == COLS) begin
            n_wraps++;
            advance_row();
          end
        end
      end
      REQ_WRITE: begin
        n_writes++;
        if (in_range) begin
          screen_model[r.row * COLS + r.col] = {r.attr, r.glyph};
        end
      end
      REQ_READ: begin
        n_reads++;
        if (in_range) begin
          cell_val = screen_model[r.row * COLS + r.col];
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    expected_results.push_back('{pos: POS_W'(cur_row * COLS + cur_col), cell_word: cell_val});
  endtask

  task automatic push_req(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] glyph,
                          input logic [COLOR_W-1:0] attr, input logic [COL_W-1:0] col,
                          input logic [ROW_W-1:0] row);
    pending_reqs.push_back('{kind: kind, glyph: glyph, attr: attr, col: col, row: row});
    reqs_queued++;
  endtask

  task automatic push_print(input logic [CHAR_W-1:0] glyph);
    push_req(REQ_PRINT, glyph, COLOR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
  endtask

  function automatic logic [CHAR_W-1:0] rand_glyph();
    logic [CHAR_W-1:0] v;
    do begin
      v = CHAR_W'($urandom_range(255));
    end while (v == NEWLINE_CODE);
    return v;
  endfunction

  function automatic logic [COL_W-1:0] pick_col();
    int r;
    r = $urandom_range(99);
    if (r < 10) return COL_W'(COLS - 1);
    if (r < 15) return '0;
    if (r < 85) return COL_W'($urandom_range(COLS - 1));
    return COL_W'($urandom_range(127, COLS));
  endfunction

  function automatic logic [ROW_W-1:0] pick_row();
    int r;
    r = $urandom_range(99);
    if (r < 10) return ROW_W'(ROWS - 1);
    if (r < 15) return '0;
    if (r < 85) return ROW_W'($urandom_range(ROWS - 1));
    return ROW_W'($urandom_range(31, ROWS));
  endfunction

  task automatic queue_random_phase(input int target);
    int first;
    int n;
    int sel;
    int k;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    first = reqs_queued;
    while (reqs_queued - first < target) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        n = $urandom_range(1, 14);
        for (k = 0; k < n; k++) push_print(rand_glyph());
        if ($urandom_range(99) < 70) push_print(NEWLINE_CODE);
      end else if (sel < 50) begin
        n = $urandom_range(COLS - 2, COLS + 4);
        for (k = 0; k < n; k++) push_print(rand_glyph());
      end else if (sel < 55) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) push_print(NEWLINE_CODE);
      end else if (sel < 70) begin
        x = pick_col();
        y = pick_row();
        push_req(REQ_WRITE, CHAR_W'($urandom), COLOR_W'($urandom), x, y);
        push_req(REQ_READ, CHAR_W'($urandom), COLOR_W'($urandom), x, y);
      end else if (sel < 85) begin
        push_req(REQ_READ, CHAR_W'($urandom), COLOR_W'($urandom), pick_col(), pick_row());
      end else if (sel < 93) begin
        push_req(REQ_WRITE, CHAR_W'($urandom), COLOR_W'($urandom), pick_col(), pick_row());
      end else begin
        push_req(REQ_UNUSED, CHAR_W'($urandom), COLOR_W'($urandom), COL_W'($urandom),
                 ROW_W'($urandom));
      end
    end
  endtask

  task automatic set_text_color(input logic [COLOR_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    print_attr = v;
    n_colors++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results_seen < reqs_queued) @(posedge clk);
  endtask

  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= '0;
      req_ch.char_code <= '0;
      req_ch.entry_color <= '0;
      req_ch.col_x <= '0;
      req_ch.row_y <= '0;
    end else begin
      offer = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        predict_request(offered_req);
        offer = 1'b0;
      end
      if (!offer) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_reqs.size() > 0) begin
          offered_req = pending_reqs.pop_front();
          offer = 1'b1;
          if ($urandom_range(99) < src_idle_pct) src_gap = $urandom_range(1, 18);
        end
      end
      req_ch.valid <= offer;
      req_ch.req_type <= offered_req.kind;
      req_ch.char_code <= offered_req.glyph;
      req_ch.entry_color <= offered_req.attr;
      req_ch.col_x <= offered_req.col;
      req_ch.row_y <= offered_req.row;
    end
  end

  always @(posedge clk) begin
    cell_result_t exp_res;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: cursor_pos %0d read_cell %h",
                   $time, rsp_ch.cursor_pos, rsp_ch.read_cell);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (rsp_ch.cursor_pos !== exp_res.pos) begin
            $display("%0t: cursor_pos mismatch, expected %0d actual %0d",
                     $time, exp_res.pos, rsp_ch.cursor_pos);
            mismatches++;
          end
          if (rsp_ch.read_cell !== exp_res.cell_word) begin
            $display("%0t: read_cell mismatch, expected %h actual %h",
                     $time, exp_res.cell_word, rsp_ch.read_cell);
            mismatches++;
          end
        end
      end
      if (hold_arm) begin
        hold_left = LONG_HOLD;
        hold_arm <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < snk_idle_pct) begin
        snk_gap = $urandom_range(1, 18) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("text_mode_terminal_writer_top_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int i;
    int phase;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.char_code = '0;
    req_ch.entry_color = '0;
    req_ch.col_x = '0;
    req_ch.row_y = '0;
    rsp_ch.ready = 1'b0;
    hold_arm = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    offered_req = '0;
    for (i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
    cur_row = 0;
    cur_col = 0;
    print_attr = TEXT_COLOR_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct <= 20;
    snk_idle_pct <= 20;

    push_req(REQ_READ, 8'h00, 8'h00, '0, '0);
    push_req(REQ_READ, 8'hff, 8'hff, COL_W'(COLS - 1), ROW_W'(ROWS - 1));
    push_print(8'h00);
    push_print(8'hff);
    push_req(REQ_WRITE, 8'hff, 8'hff, COL_W'(COLS - 1), ROW_W'(ROWS - 1));
    push_req(REQ_READ, 8'h00, 8'h00, COL_W'(COLS - 1), ROW_W'(ROWS - 1));
    push_req(REQ_WRITE, 8'h00, 8'h00, COL_W'(COLS - 1), '0);
    push_req(REQ_READ, 8'h00, 8'h00, COL_W'(COLS - 1), '0);
    push_req(REQ_WRITE, 8'h5a, 8'ha5, COL_W'(COLS), '0);
    push_req(REQ_WRITE, 8'hff, 8'hff, 7'h7f, 5'h1f);
    push_req(REQ_WRITE, 8'h3c, 8'hc3, '0, ROW_W'(ROWS));
    push_req(REQ_READ, 8'h00, 8'h00, COL_W'(COLS), '0);
    push_req(REQ_READ, 8'hff, 8'hff, 7'h7f, 5'h1f);
    push_req(REQ_READ, 8'h00, 8'h00, '0, ROW_W'(ROWS));
    push_req(REQ_UNUSED, 8'hff, 8'hff, 7'h7f, 5'h1f);
    push_req(REQ_UNUSED, 8'h00, 8'h00, '0, '0);
    push_print(NEWLINE_CODE);
    push_req(REQ_READ, 8'h00, 8'h00, '0, '0);
    push_req(REQ_READ, 8'h00, 8'h00, 7'd1, '0);
    push_print(8'h41);
    push_req(REQ_READ, 8'h00, 8'h00, '0, 5'd1);
    wait_drained();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_text_color(8'hff);
        1: set_text_color(8'h00);
        4: set_text_color(TEXT_COLOR_RESET);
        default: set_text_color(COLOR_W'($urandom));
      endcase
      src_idle_pct <= (phase == 2 || phase == 4) ? 0 : $urandom_range(5, 30);
      snk_idle_pct <= (phase == 4) ? 0 : $urandom_range(5, 30);
      if (phase == 0) begin
        for (i = 0; i < ROWS + 1; i++) push_print(NEWLINE_CODE);
      end
      queue_random_phase(PHASE_ITEMS);
      if (phase == 2) hold_arm <= 1'b1;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("Covered %0d prints with %0d line wraps and %0d scrolls, %0d cell writes,",
             n_prints, n_wraps, n_scrolls, n_writes);
    $display("%0d cell reads and %0d unused requests under %0d text colors; %0d mismatches.",
             n_reads, n_unused, n_colors + 1, mismatches);
    if (mismatches == 0) begin
      $display("text_mode_terminal_writer_top_tb: PASS");
    end else begin
      $display("text_mode_terminal_writer_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== text_mode_terminal_writer_top.f =====
rtl/core/tmtw_pkg.sv
rtl/core/tmtw_if.sv
rtl/core/tmtw_store.sv
rtl/core/tmtw_result.sv
rtl/core/tmtw_ctrl.sv
rtl/core/text_mode_terminal_writer_top.sv
tb/sv/text_mode_terminal_writer_top_tb.sv
